FILE: rtl/ddmc_pkg.sv
// ============================================================================
// ddmc_pkg
// Shared types, codes and constants of the differential-drive motor controller.
// ============================================================================
package ddmc_pkg;

   // Width of the saturating idle-millisecond counter.
   localparam int IDLE_COUNTER_BITS = 16;
   localparam int WDOG_BITS         = 16;
   localparam int IDLE_CMP_BITS     = (IDLE_COUNTER_BITS > WDOG_BITS) ?
                                      IDLE_COUNTER_BITS : WDOG_BITS;

   // Configuration port geometry: five 32-bit registers at word addresses.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Square root unit: radicand below 2^30, root below 2^15.
   localparam int SQ_IN_BITS  = 30;
   localparam int SQ_OUT_BITS = 15;

   // Shared multiplier geometry.
   localparam int MUL_IN_BITS  = 16;
   localparam int MUL_OUT_BITS = 32;

   // Floor division by 100 for values below 25600: (v * 5243) >> 19.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic signed [8:0] JOY_LIMIT     = 9'sd100;
   localparam logic [13:0]       RADIUS_SQ_MAX = 14'd10000;
   localparam logic [6:0]        FLOOR_MAG_MIN = 7'd5;

   // Input operation codes.
   localparam logic [1:0] OP_JOY  = 2'd0;
   localparam logic [1:0] OP_DIR  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Direction command codes.
   localparam logic [2:0] DIR_STOP  = 3'd0;
   localparam logic [2:0] DIR_FWD   = 3'd1;
   localparam logic [2:0] DIR_BWD   = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MIN_PWM   = 3'd0;
   localparam logic [2:0] REG_MAX_PWM   = 3'd1;
   localparam logic [2:0] REG_DEADZONE  = 3'd2;
   localparam logic [2:0] REG_DEAD_TIME = 3'd3;
   localparam logic [2:0] REG_WATCHDOG  = 3'd4;

   // Register reset values.
   localparam logic [7:0]  RST_MIN_PWM   = 8'd50;
   localparam logic [7:0]  RST_MAX_PWM   = 8'd255;
   localparam logic [6:0]  RST_DEADZONE  = 7'd10;
   localparam logic [9:0]  RST_DEAD_TIME = 10'd100;
   localparam logic [15:0] RST_WATCHDOG  = 16'd500;
   localparam logic [7:0]  RST_SPEED     = 8'd255;

   // Bridge pin pairs of one side: bit 0 forward input, bit 1 reverse input.
   localparam logic [1:0] SIDE_OFF = 2'b00;
   localparam logic [1:0] SIDE_FWD = 2'b01;
   localparam logic [1:0] SIDE_REV = 2'b10;

   typedef enum logic [2:0] {
      ACT_STOP, ACT_OBSTACLE, ACT_JOY, ACT_FWD,
      ACT_BWD, ACT_LEFT, ACT_RIGHT, ACT_WATCHDOG
   } action_type;

   typedef struct packed {
      logic [7:0]  min_pwm;
      logic [7:0]  max_pwm;
      logic [6:0]  deadzone;
      logic [9:0]  dead_time_ms;
      logic [15:0] watchdog_ms;
   } cfg_type;

   // Pins: [1:0] left side, [3:2] right side.
   typedef struct packed {
      logic [3:0] pins;
      logic [7:0] left_pwm;
      logic [7:0] right_pwm;
      action_type action;
      logic       cut_phase;
      logic [9:0] hold_ms;
      logic       last;
   } rsp_beat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_JOY_SQX, S_JOY_SQY, S_JOY_D2, S_JOY_CHECK, S_JOY_SCALE,
      S_ROOT_START, S_ROOT_WAIT, S_BASE, S_LEFT_MUL, S_LEFT_DIV,
      S_RIGHT_MUL, S_RIGHT_DIV, S_DUTY, S_DIR, S_TICK, S_CUT, S_MAIN
   } seq_state_type;

   function automatic logic signed [7:0] clamp100(input logic signed [8:0] v);
      logic signed [8:0] r;
      if (v < -JOY_LIMIT) begin
         r = -JOY_LIMIT;
      end else if (v > JOY_LIMIT) begin
         r = JOY_LIMIT;
      end else begin
         r = v;
      end
      return r[7:0];
   endfunction

   function automatic logic [6:0] abs7(input logic signed [7:0] v);
      logic [7:0] r;
      r = v[7] ? 8'(-v) : 8'(v);
      return r[6:0];
   endfunction

   function automatic logic side_reverses(input logic [1:0] old_p,
                                          input logic [1:0] new_p);
      return (old_p != SIDE_OFF) && (new_p != SIDE_OFF) && (old_p != new_p);
   endfunction

endpackage

FILE: rtl/differential_drive_motor_controller.sv
// ============================================================================
// differential_drive_motor_controller
// Arcade mixer and bridge sequencer for a two-motor differential drive.
// ============================================================================
// The block takes one command beat at a time and answers with up to two
// result beats. A joystick beat that drives the motors starts the iterative
// square root that scales the base speed and waits out its 15 steps. Its
// other steps use the single 16x16 multiplier that forms the squares, the
// scale product and the divisions by 100, and then load the result. When
// the ceiling is below the floor there is no square root. A joystick beat
// that stops in the deadzone or at an obstacle skips the scaling. A tick
// answers only when the watchdog stops the motors. The dead-time cut beat
// before a polarity reversal is loaded in the cut state that every driving
// command passes through anyway. While rsp_stall holds the result register,
// a cut or final beat waits to be loaded. While a command is being worked
// on, req_stall is high. A finished result may still sit in the output
// register while the next command is accepted. The five configuration
// registers lie at byte addresses 0, 4, 8, 12 and 16 and must only be written
// while idle.
// ============================================================================
module differential_drive_motor_controller
   import ddmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   // Command channel.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic signed [7:0]        req_joy_x,
   input  logic signed [7:0]        req_joy_y,
   input  logic [2:0]               req_direction,
   input  logic                     req_obstacle,

   // Result channel.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_left_fwd,
   output logic                     rsp_left_rev,
   output logic                     rsp_right_fwd,
   output logic                     rsp_right_rev,
   output logic [7:0]               rsp_left_pwm,
   output logic [7:0]               rsp_right_pwm,
   output logic [2:0]               rsp_action,
   output logic                     rsp_cut_phase,
   output logic [9:0]               rsp_hold_ms,
   output logic                     rsp_last,

   // Configuration port.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type cfg;

   // Sequencer.
   seq_state_type state_ff, state_in;

   // Captured command, with the stick already clamped to +/-100.
   logic signed [7:0] x_ff, x_in;
   logic signed [7:0] y_ff, y_in;
   logic [2:0]        dir_ff, dir_in;
   logic              obst_ff, obst_in;

   // Working registers of the joystick path.
   logic [13:0] xsq_ff, xsq_in;
   logic [14:0] d2_ff, d2_in;
   logic [7:0]  ql_ff, ql_in;

   // Shared multiplier with its registered product.
   logic [MUL_IN_BITS-1:0]  mult_a, mult_b;
   logic [MUL_OUT_BITS-1:0] prod_ff, prod_in;

   // Square root unit handshake.
   logic                   sq_start;
   logic                   sq_done;
   logic [SQ_OUT_BITS-1:0] sq_root;

   // Drive the bridges will get once this command completes.
   logic [3:0] new_pins_ff, new_pins_in;
   logic [7:0] new_l_ff, new_l_in;
   logic [7:0] new_r_ff, new_r_in;
   action_type new_act_ff, new_act_in;

   // Architectural state.
   logic [3:0]                   pins_ff, pins_in;
   action_type                   act_ff, act_in;
   logic [7:0]                   speed_ff, speed_in;
   logic [IDLE_COUNTER_BITS-1:0] idle_ff, idle_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;
   logic         rsp_load;
   logic         rsp_load_cut;

   // Decision helpers.
   logic                         req_take;
   logic                         out_free;
   logic signed [7:0]            lr, rr;
   logic [6:0]                   abs_x, abs_y, abs_lr, abs_rr;
   logic [7:0]                   diff;
   logic [13:0]                  m2;
   logic                         joy_dead, joy_blocked, cfg_inverted;
   logic                         reverses;
   logic [IDLE_COUNTER_BITS-1:0] idle_sat;
   logic                         wdog_fire;
   logic [7:0]                   quot;
   logic [8:0]                   base;
   logic [7:0]                   dir_speed;
   logic [7:0]                   duty_l, duty_r;

   ddmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ddmc_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (prod_ff[SQ_IN_BITS-1:0]),
      .done    (sq_done),
      .root    (sq_root)
   );

   // ---------------------------------------------------------------------
   // Handshakes. The command side is open only in the idle state; the result
   // register can take a new beat whenever it is empty or being drained.
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Combinational helpers shared by the sequencer and the datapath.
   // ---------------------------------------------------------------------
   assign lr     = clamp100($signed({y_ff[7], y_ff}) + $signed({x_ff[7], x_ff}));
   assign rr     = clamp100($signed({y_ff[7], y_ff}) - $signed({x_ff[7], x_ff}));
   assign abs_x  = abs7(x_ff);
   assign abs_y  = abs7(y_ff);
   assign abs_lr = abs7(lr);
   assign abs_rr = abs7(rr);
   assign diff   = cfg.max_pwm - cfg.min_pwm;
   assign m2     = (d2_ff > 15'(RADIUS_SQ_MAX)) ? RADIUS_SQ_MAX : d2_ff[13:0];

   // In the check state the product register holds deadzone squared.
   assign joy_dead     = (d2_ff < 15'(prod_ff[13:0]));
   assign joy_blocked  = !y_ff[7] && (y_ff != 8'sd0) && obst_ff;
   assign cfg_inverted = (cfg.max_pwm < cfg.min_pwm);

   // A cut beat is due when either bridge flips from one driven polarity to
   // the other; going to or from all-off needs none.
   assign reverses = side_reverses(pins_ff[1:0], new_pins_ff[1:0]) ||
                     side_reverses(pins_ff[3:2], new_pins_ff[3:2]);

   assign idle_sat  = (&idle_ff) ? idle_ff : idle_ff + 1'b1;
   assign wdog_fire = (act_ff >= ACT_JOY) && (act_ff <= ACT_RIGHT) &&
                      (IDLE_CMP_BITS'(idle_sat) > IDLE_CMP_BITS'(cfg.watchdog_ms));

   // Quotient by 100 out of the reciprocal product.
   assign quot = prod_ff[RECIP_SHIFT +: 8];
   assign base = {1'b0, cfg.min_pwm} + {1'b0, quot};

   assign dir_speed = (speed_ff > cfg.max_pwm) ? cfg.max_pwm : speed_ff;

   // Side duty: truncated scale, raised to the PWM floor once the stick is
   // clearly off center, and finally limited to the ceiling.
   always_comb begin
      duty_l = ql_ff;
      if (abs_lr > FLOOR_MAG_MIN && duty_l < cfg.min_pwm) begin
         duty_l = cfg.min_pwm;
      end
      if (duty_l > cfg.max_pwm) begin
         duty_l = cfg.max_pwm;
      end
      duty_r = quot;
      if (abs_rr > FLOOR_MAG_MIN && duty_r < cfg.min_pwm) begin
         duty_r = cfg.min_pwm;
      end
      if (duty_r > cfg.max_pwm) begin
         duty_r = cfg.max_pwm;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer next state.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               unique case (req_op)
                  OP_JOY:  state_in = S_JOY_SQX;
                  OP_DIR:  state_in = S_DIR;
                  OP_TICK: state_in = S_TICK;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_JOY_SQX: state_in = S_JOY_SQY;
         S_JOY_SQY: state_in = S_JOY_D2;
         S_JOY_D2:  state_in = S_JOY_CHECK;
         S_JOY_CHECK: begin
            priority if (joy_dead || joy_blocked) begin
               state_in = S_MAIN;
            end else if (cfg_inverted) begin
               state_in = S_LEFT_MUL;
            end else begin
               state_in = S_JOY_SCALE;
            end
         end
         S_JOY_SCALE:  state_in = S_ROOT_START;
         S_ROOT_START: state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (sq_done) begin
               state_in = S_BASE;
            end
         end
         S_BASE:      state_in = S_LEFT_MUL;
         S_LEFT_MUL:  state_in = S_LEFT_DIV;
         S_LEFT_DIV:  state_in = S_RIGHT_MUL;
         S_RIGHT_MUL: state_in = S_RIGHT_DIV;
         S_RIGHT_DIV: state_in = S_DUTY;
         S_DUTY:      state_in = S_CUT;
         S_DIR:       state_in = S_CUT;
         S_TICK: begin
            state_in = wdog_fire ? S_MAIN : S_IDLE;
         end
         S_CUT: begin
            if (!reverses || out_free) begin
               state_in = S_MAIN;
            end
         end
         S_MAIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs: multiplier operands, root start and result loads.
   // ---------------------------------------------------------------------
   always_comb begin
      mult_a       = '0;
      mult_b       = '0;
      sq_start     = 1'b0;
      rsp_load     = 1'b0;
      rsp_load_cut = 1'b0;
      unique case (state_ff)
         S_JOY_SQX: begin
            mult_a = MUL_IN_BITS'(abs_x);
            mult_b = MUL_IN_BITS'(abs_x);
         end
         S_JOY_SQY: begin
            mult_a = MUL_IN_BITS'(abs_y);
            mult_b = MUL_IN_BITS'(abs_y);
         end
         S_JOY_D2: begin
            mult_a = MUL_IN_BITS'(cfg.deadzone);
            mult_b = MUL_IN_BITS'(cfg.deadzone);
         end
         S_JOY_CHECK: begin
            mult_a = MUL_IN_BITS'(diff);
            mult_b = MUL_IN_BITS'(diff);
         end
         S_JOY_SCALE: begin
            mult_a = MUL_IN_BITS'(m2);
            mult_b = prod_ff[MUL_IN_BITS-1:0];
         end
         S_ROOT_START: begin
            sq_start = 1'b1;
         end
         S_ROOT_WAIT: begin
            mult_a = MUL_IN_BITS'(sq_root);
            mult_b = MUL_IN_BITS'(RECIP_100);
         end
         S_LEFT_MUL: begin
            mult_a = MUL_IN_BITS'(abs_lr);
            mult_b = MUL_IN_BITS'(speed_ff);
         end
         S_LEFT_DIV, S_RIGHT_DIV: begin
            mult_a = MUL_IN_BITS'(prod_ff[14:0]);
            mult_b = MUL_IN_BITS'(RECIP_100);
         end
         S_RIGHT_MUL: begin
            mult_a = MUL_IN_BITS'(abs_rr);
            mult_b = MUL_IN_BITS'(speed_ff);
         end
         S_CUT: begin
            if (reverses && out_free) begin
               rsp_load     = 1'b1;
               rsp_load_cut = 1'b1;
            end
         end
         S_MAIN: begin
            rsp_load = out_free;
         end
         default: begin
            mult_a = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values.
   // ---------------------------------------------------------------------
   assign prod_in = MUL_OUT_BITS'(mult_a) * MUL_OUT_BITS'(mult_b);

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      dir_in      = dir_ff;
      obst_in     = obst_ff;
      xsq_in      = xsq_ff;
      d2_in       = d2_ff;
      ql_in       = ql_ff;
      new_pins_in = new_pins_ff;
      new_l_in    = new_l_ff;
      new_r_in    = new_r_ff;
      new_act_in  = new_act_ff;
      pins_in     = pins_ff;
      act_in      = act_ff;
      speed_in    = speed_ff;
      idle_in     = idle_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in    = clamp100($signed({req_joy_x[7], req_joy_x}));
               y_in    = clamp100($signed({req_joy_y[7], req_joy_y}));
               dir_in  = req_direction;
               obst_in = req_obstacle;
               if (req_op == OP_JOY || req_op == OP_DIR) begin
                  idle_in = '0;
               end
            end
         end
         S_JOY_SQY: xsq_in = prod_ff[13:0];
         S_JOY_D2:  d2_in  = {1'b0, xsq_ff} + {1'b0, prod_ff[13:0]};
         S_JOY_CHECK: begin
            new_pins_in = '0;
            new_l_in    = '0;
            new_r_in    = '0;
            priority if (joy_dead) begin
               new_act_in = ACT_STOP;
            end else if (joy_blocked) begin
               new_act_in = ACT_OBSTACLE;
            end else begin
               new_act_in = ACT_JOY;
               if (cfg_inverted) begin
                  speed_in = cfg.max_pwm;
               end
            end
         end
         S_BASE: begin
            speed_in = (base > {1'b0, cfg.max_pwm}) ? cfg.max_pwm : base[7:0];
         end
         S_RIGHT_MUL: ql_in = quot;
         S_DUTY: begin
            new_pins_in = {rr[7] ? SIDE_REV : SIDE_FWD, lr[7] ? SIDE_REV : SIDE_FWD};
            new_l_in    = duty_l;
            new_r_in    = duty_r;
         end
         S_DIR: begin
            new_l_in = dir_speed;
            new_r_in = dir_speed;
            unique case (dir_ff)
               DIR_FWD: begin
                  if (obst_ff) begin
                     new_pins_in = '0;
                     new_l_in    = '0;
                     new_r_in    = '0;
                     new_act_in  = ACT_OBSTACLE;
                  end else begin
                     new_pins_in = {SIDE_FWD, SIDE_FWD};
                     new_act_in  = ACT_FWD;
                  end
               end
               DIR_BWD: begin
                  new_pins_in = {SIDE_REV, SIDE_REV};
                  new_act_in  = ACT_BWD;
               end
               DIR_LEFT: begin
                  new_pins_in = {SIDE_FWD, SIDE_REV};
                  new_act_in  = ACT_LEFT;
               end
               DIR_RIGHT: begin
                  new_pins_in = {SIDE_REV, SIDE_FWD};
                  new_act_in  = ACT_RIGHT;
               end
               default: begin
                  new_pins_in = '0;
                  new_l_in    = '0;
                  new_r_in    = '0;
                  new_act_in  = ACT_STOP;
               end
            endcase
         end
         S_TICK: begin
            idle_in     = idle_sat;
            new_pins_in = '0;
            new_l_in    = '0;
            new_r_in    = '0;
            new_act_in  = ACT_WATCHDOG;
         end
         S_MAIN: begin
            if (out_free) begin
               pins_in = new_pins_ff;
               act_in  = new_act_ff;
            end
         end
         default: begin
            ql_in = ql_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register. A cut beat shows the new action with every pin and
   // duty off and the dead time to hold; the driving beat closes the item.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (rsp_load_cut) begin
            rsp_beat_in.pins      = '0;
            rsp_beat_in.left_pwm  = '0;
            rsp_beat_in.right_pwm = '0;
            rsp_beat_in.cut_phase = 1'b1;
            rsp_beat_in.hold_ms   = cfg.dead_time_ms;
            rsp_beat_in.last      = 1'b0;
         end else begin
            rsp_beat_in.pins      = new_pins_ff;
            rsp_beat_in.left_pwm  = new_l_ff;
            rsp_beat_in.right_pwm = new_r_ff;
            rsp_beat_in.cut_phase = 1'b0;
            rsp_beat_in.hold_ms   = '0;
            rsp_beat_in.last      = 1'b1;
         end
         rsp_beat_in.action = new_act_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_fwd  = rsp_beat_ff.pins[0];
   assign rsp_left_rev  = rsp_beat_ff.pins[1];
   assign rsp_right_fwd = rsp_beat_ff.pins[2];
   assign rsp_right_rev = rsp_beat_ff.pins[3];
   assign rsp_left_pwm  = rsp_beat_ff.left_pwm;
   assign rsp_right_pwm = rsp_beat_ff.right_pwm;
   assign rsp_action    = rsp_beat_ff.action;
   assign rsp_cut_phase = rsp_beat_ff.cut_phase;
   assign rsp_hold_ms   = rsp_beat_ff.hold_ms;
   assign rsp_last      = rsp_beat_ff.last;

   // ---------------------------------------------------------------------
   // Registers. Control and architectural state reset; working registers
   // and the result payload do not.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pins_ff      <= '0;
         act_ff       <= ACT_STOP;
         speed_ff     <= RST_SPEED;
         idle_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pins_ff      <= pins_in;
         act_ff       <= act_in;
         speed_ff     <= speed_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      dir_ff      <= dir_in;
      obst_ff     <= obst_in;
      xsq_ff      <= xsq_in;
      d2_ff       <= d2_in;
      ql_ff       <= ql_in;
      prod_ff     <= prod_in;
      new_pins_ff <= new_pins_in;
      new_l_ff    <= new_l_in;
      new_r_ff    <= new_r_in;
      new_act_ff  <= new_act_in;
      rsp_beat_ff <= rsp_beat_in;
   end

endmodule

FILE: rtl/ddmc_csr.sv
// ============================================================================
// ddmc_csr
// Configuration registers behind a simple APB-style slave port.
// ============================================================================
module ddmc_csr
   import ddmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_PWM:   cfg_in.min_pwm      = pwdata[7:0];
            REG_MAX_PWM:   cfg_in.max_pwm      = pwdata[7:0];
            REG_DEADZONE:  cfg_in.deadzone     = pwdata[6:0];
            REG_DEAD_TIME: cfg_in.dead_time_ms = pwdata[9:0];
            REG_WATCHDOG:  cfg_in.watchdog_ms  = pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_PWM:   prdata = 32'(cfg_ff.min_pwm);
         REG_MAX_PWM:   prdata = 32'(cfg_ff.max_pwm);
         REG_DEADZONE:  prdata = 32'(cfg_ff.deadzone);
         REG_DEAD_TIME: prdata = 32'(cfg_ff.dead_time_ms);
         REG_WATCHDOG:  prdata = 32'(cfg_ff.watchdog_ms);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pwm      <= RST_MIN_PWM;
         cfg_ff.max_pwm      <= RST_MAX_PWM;
         cfg_ff.deadzone     <= RST_DEADZONE;
         cfg_ff.dead_time_ms <= RST_DEAD_TIME;
         cfg_ff.watchdog_ms  <= RST_WATCHDOG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ddmc_isqrt.sv
// ============================================================================
// ddmc_isqrt
// Iterative integer square root, one result bit per clock cycle.
// ============================================================================
module ddmc_isqrt
   import ddmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SQ_IN_BITS-1:0]  operand,
   output logic                   done,
   output logic [SQ_OUT_BITS-1:0] root
);

   logic [SQ_IN_BITS-1:0] rem_ff, rem_in;
   logic [SQ_IN_BITS-1:0] res_ff, res_in;
   logic [SQ_IN_BITS-1:0] bit_ff, bit_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQ_IN_BITS:0]   trial;

   // The trial subtrahend is the partial root plus the current bit pair.
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign done  = done_ff;
   assign root  = res_ff[SQ_OUT_BITS-1:0];

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         bit_in  = SQ_IN_BITS'(1) << (SQ_IN_BITS - 2);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[SQ_IN_BITS-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQ_IN_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule

FILE: rtl/ddmc_checker.sv
// ============================================================================
// ddmc_checker
// Port-level checks of the motor controller, bound to the top level.
// ============================================================================
module ddmc_checker
   import ddmc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_left_fwd,
   input logic       rsp_left_rev,
   input logic       rsp_right_fwd,
   input logic       rsp_right_rev,
   input logic [7:0] rsp_left_pwm,
   input logic [7:0] rsp_right_pwm,
   input logic       rsp_cut_phase,
   input logic [9:0] rsp_hold_ms,
   input logic       rsp_last
);

   // Only one command is worked on at a time; an unknown op is dropped at once.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_op == OP_JOY || req_op == OP_DIR || req_op == OP_TICK) |=> req_stall)
      else $error("command accepted while the previous one is still running");

   // A dead-time cut drives nothing and is always followed by another beat.
   a_cut_is_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_phase |-> !rsp_last && rsp_left_pwm == 8'd0 &&
      rsp_right_pwm == 8'd0 && !rsp_left_fwd && !rsp_left_rev &&
      !rsp_right_fwd && !rsp_right_rev)
      else $error("cut beat drives a bridge or closes the command");

   // Only a cut beat leaves a command open, and only it carries a hold time.
   a_open_only_on_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cut_phase |-> rsp_last && rsp_hold_ms == 10'd0)
      else $error("driving beat not final or carries a hold time");

   // A driving beat never shorts a bridge.
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_left_fwd && rsp_left_rev) &&
      !(rsp_right_fwd && rsp_right_rev))
      else $error("both inputs of one bridge driven");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_pwm) &&
      $stable(rsp_right_pwm) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind differential_drive_motor_controller ddmc_checker u_ddmc_checker (.*);
